@@ rtl/core/lis_pkg.sv @@
`default_nettype none

package lis_pkg;

	// Default sequence capacity
	localparam int MAX_ITEMS_DEF = 64;

	// Field widths
	localparam int VAL_W     = 32;
	localparam int LEN_W     = 7;
	localparam int TDATA_I_W = 32;
	localparam int TDATA_O_W = 40;

	// Engine sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,   // wait for a word
		ST_SCAN,   // compare new value against stored entries
		ST_WRITE,  // store value and length, update best
		ST_PUSH,   // push current index onto trace stack
		ST_LOAD,   // latch value/length of current index
		ST_TSCAN,  // search earliest predecessor
		ST_ERD,    // read trace stack
		ST_EVAL,   // read element at traced index
		ST_EOUT    // hand result to output stage
	} lis_state_t;

	// One result word
	typedef struct packed {
		logic                    last;
		logic signed [VAL_W-1:0] element;
		logic [LEN_W-1:0]        length;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/core/lis_ram.sv @@
`default_nettype none

module lis_ram
	import lis_pkg::*;
#(
	parameter int WIDTH = VAL_W,
	parameter int DEPTH = MAX_ITEMS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output      logic [WIDTH-1:0]           rd_data_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle; read data holds when idle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lis_engine.sv @@
`default_nettype none

module lis_engine
	import lis_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire logic signed [VAL_W-1:0] in_value,
	input  wire logic                    in_last,
	output      logic                    res_valid,
	input  wire logic                    res_ready,
	output      res_t                    res
);

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);

	lis_state_t state_q, state_d;

	// control state
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] best_len_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [LEN_W-1:0] k_q;
	logic             iss_act_q;
	logic             chk_s1;

	// working registers
	logic signed [VAL_W-1:0] val_q;
	logic [LEN_W-1:0]        len_q;
	logic [IDX_W-1:0]        pos_q;
	logic [IDX_W-1:0]        lim_q;
	logic                    last_q;
	logic [IDX_W-1:0]        cur_q;
	logic [IDX_W-1:0]        iss_q;
	logic [IDX_W-1:0]        chk_idx_s1;

	// memory ports
	logic                    seq_rd_en;
	logic [IDX_W-1:0]        seq_rd_addr;
	logic [LEN_W+VAL_W-1:0]  seq_rd_data;
	logic                    seq_wr_en;
	logic                    stk_wr_en;
	logic [IDX_W-1:0]        stk_wr_addr;
	logic                    stk_rd_en;
	logic [IDX_W-1:0]        stk_rd_data;

	logic signed [VAL_W-1:0] dout_val;
	logic [LEN_W-1:0]        dout_len;
	logic [LEN_W-1:0]        dout_len_p1;
	logic [IDX_W-1:0]        lim_m1;
	logic                    dout_less;
	logic                    chk_last;
	logic                    scan_hit;
	logic                    trace_hit;
	logic                    scan_rd;
	logic                    accept;
	logic                    full;
	logic                    nb_upd;
	logic [LEN_W-1:0]        nb_len;
	logic [IDX_W-1:0]        nb_idx;
	logic                    emit_done;

	// value and length per index, one entry per stored word
	lis_ram #(
		.WIDTH(LEN_W + VAL_W),
		.DEPTH(MAX_ITEMS)
	) u_seq_ram (
		.clk      (clk),
		.wr_en    (seq_wr_en),
		.wr_addr  (pos_q),
		.wr_data  ({len_q, val_q}),
		.rd_en    (seq_rd_en),
		.rd_addr  (seq_rd_addr),
		.rd_data_q(seq_rd_data)
	);

	// traced indices, filled from the end backward
	lis_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_ITEMS)
	) u_stk_ram (
		.clk      (clk),
		.wr_en    (stk_wr_en),
		.wr_addr  (stk_wr_addr),
		.wr_data  (cur_q),
		.rd_en    (stk_rd_en),
		.rd_addr  (k_q[IDX_W-1:0]),
		.rd_data_q(stk_rd_data)
	);

	// compare datapath
	always_comb begin
		dout_len    = seq_rd_data[LEN_W+VAL_W-1:VAL_W];
		dout_val    = seq_rd_data[VAL_W-1:0];
		dout_len_p1 = dout_len + 1'b1;
		lim_m1      = lim_q - 1'b1;
		dout_less   = dout_val < val_q;
		chk_last    = chk_s1 && (chk_idx_s1 == lim_m1);
		scan_hit    = chk_s1 && dout_less && (dout_len_p1 > len_q);
		trace_hit   = chk_s1 && dout_less && (dout_len_p1 == len_q);
		accept      = in_valid && in_ready;
		full        = count_q == CNT_FULL;
		nb_upd      = len_q > best_len_q;
		nb_len      = nb_upd ? len_q : best_len_q;
		nb_idx      = nb_upd ? pos_q : best_idx_q;
		emit_done   = k_q == LEN_W'(best_len_q - 1'b1);
		stk_wr_addr = IDX_W'(k_q - 1'b1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (full) begin
						state_d = in_last ? ST_PUSH : ST_IDLE;
					end else if (count_q == '0) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (chk_last) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = last_q ? ST_PUSH : ST_IDLE;
			end
			ST_PUSH: begin
				state_d = (k_q == LEN_W'(1)) ? ST_ERD : ST_LOAD;
			end
			ST_LOAD: begin
				state_d = (cur_q == '0) ? ST_PUSH : ST_TSCAN;
			end
			ST_TSCAN: begin
				if (trace_hit || chk_last) state_d = ST_PUSH;
			end
			ST_ERD: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_EOUT;
			end
			ST_EOUT: begin
				if (res_ready) state_d = emit_done ? ST_IDLE : ST_ERD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		seq_rd_en   = 1'b0;
		seq_rd_addr = iss_q;
		seq_wr_en   = 1'b0;
		stk_wr_en   = 1'b0;
		stk_rd_en   = 1'b0;
		scan_rd     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN, ST_TSCAN: begin
				seq_rd_en = iss_act_q;
				scan_rd   = iss_act_q;
			end
			ST_WRITE: begin
				seq_wr_en = 1'b1;
			end
			ST_PUSH: begin
				stk_wr_en   = 1'b1;
				seq_rd_en   = k_q != LEN_W'(1);
				seq_rd_addr = cur_q;
			end
			ST_ERD: begin
				stk_rd_en = 1'b1;
			end
			ST_EVAL: begin
				seq_rd_en   = 1'b1;
				seq_rd_addr = stk_rd_data;
			end
			ST_EOUT: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign res.last    = emit_done;
	assign res.element = dout_val;
	assign res.length  = best_len_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			best_len_q <= LEN_W'(1);
			best_idx_q <= '0;
			k_q        <= '0;
			iss_act_q  <= 1'b0;
			chk_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= scan_rd;
			// read issue runs from index 0 up to lim - 1
			if (scan_rd && (iss_q == lim_m1)) begin
				iss_act_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= best_len_q;
						if (!full && (count_q != '0)) iss_act_q <= 1'b1;
					end
				end
				ST_WRITE: begin
					count_q    <= count_q + 1'b1;
					best_len_q <= nb_len;
					best_idx_q <= nb_idx;
					k_q        <= nb_len;
				end
				ST_PUSH: begin
					k_q <= k_q - 1'b1;
				end
				ST_LOAD: begin
					if (cur_q != '0) iss_act_q <= 1'b1;
				end
				ST_EOUT: begin
					if (res_ready) begin
						if (emit_done) begin
							count_q    <= '0;
							best_len_q <= LEN_W'(1);
							best_idx_q <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		chk_idx_s1 <= iss_q;
		if (scan_rd) iss_q <= iss_q + 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_q  <= in_value;
					last_q <= in_last;
					pos_q  <= count_q[IDX_W-1:0];
					lim_q  <= count_q[IDX_W-1:0];
					len_q  <= LEN_W'(1);
					iss_q  <= '0;
					cur_q  <= best_idx_q;
				end
			end
			ST_SCAN: begin
				if (scan_hit) len_q <= dout_len_p1;
			end
			ST_WRITE: begin
				cur_q <= nb_idx;
			end
			ST_LOAD: begin
				val_q <= dout_val;
				len_q <= dout_len;
				lim_q <= cur_q;
				iss_q <= '0;
			end
			ST_TSCAN: begin
				if (trace_hit) cur_q <= chk_idx_s1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/longest_increasing_subsequence.sv @@
// Longest strictly increasing subsequence of a signed 32-bit stream.
//
// Input channel s_*: one word per sequence element, s_tlast on the final one.
// Output channel m_*: one word per element of the subsequence, in original
// order, each carrying the subsequence length; m_tlast marks its final word.
// Up to MAX_ITEMS elements are kept; further elements of a sequence are
// dropped, a dropped word with s_tlast still closes the sequence.
// Each element is compared with every stored entry by one sequential read
// per entry from the value/length memory. After the last element each
// trace-back step searches the entries below the current index, and each
// output word is read from the trace stack, then the value/length memory.
// One sequence is processed at a time; s_tready is low from the closing
// word until the final output word is handed to the output register.
// A stalled receiver holds the output register and halts the emitter.
// Reset clears counters and best-length tracking; memory contents need no
// clearing since every entry is written before it is read.
`default_nettype none

module longest_increasing_subsequence
	import lis_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [TDATA_I_W-1:0] s_tdata,  // [31:0] value
	input  wire logic                 s_tlast,
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [TDATA_O_W-1:0] m_tdata,  // [6:0] length, [38:7] element
	output      logic                 m_tlast
);

	localparam int PAD_W = TDATA_O_W - LEN_W - VAL_W;

	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_q;
	logic out_vld_q;

	lis_engine #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata[VAL_W-1:0]),
		.in_last  (s_tlast),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_q.element, out_q.length};
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

@@ rtl/core/lis_chk.sv @@
`default_nettype none

module lis_chk
	import lis_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 s_tlast,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [TDATA_O_W-1:0] m_tdata,
	input wire logic                 m_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// reported length is within 1..MAX_ITEMS
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[LEN_W-1:0] != '0) &&
			(m_tdata[LEN_W-1:0] <= LEN_W'(MAX_ITEMS)))
		else $error("output length out of range");

	// no input taken while a subsequence is still being emitted
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready during emission");

	// closing word starts trace-back, input is blocked next cycle
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input ready right after closing word");

endmodule

bind longest_increasing_subsequence lis_chk #(
	.MAX_ITEMS(MAX_ITEMS)
) u_lis_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire
